FILE: design/tsp_pkg.sv
// tsp_pkg: shared types, codes, defaults and the tone step table of the tone sequence player
// no dependencies
package tsp_pkg;

    // default table geometry
    localparam int NUM_TONES_DEF      = 4;
    localparam int STEPS_PER_TONE_DEF = 4;

    // field widths
    localparam int OP_W   = 2;
    localparam int TONE_W = 3;
    localparam int FREQ_W = 16;
    localparam int DUR_W  = 16;
    localparam int DUTY_W = 8;

    // side of the fixed table, in rows and in slots per row
    localparam int TABLE_DIM = 16;
    localparam int TIDX_W    = $clog2(TABLE_DIM);

    localparam logic [DUTY_W-1:0] SOUND_DUTY = 8'd128;
    localparam logic [DUR_W-1:0]  ELAPSED_MAX = 16'hFFFF;

    // operation codes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_MUTE = 2'd2
    } t_op;

    // one step: frequency and duration, zero/zero ends the sequence
    typedef struct packed {
        logic [FREQ_W-1:0] hz;
        logic [DUR_W-1:0]  len_ms;
    } t_seq_entry;

    // fixed step table, every slot not listed is an end step
    function automatic t_seq_entry seq_table(input logic [TIDX_W-1:0] t,
                                             input logic [TIDX_W-1:0] s);
        t_seq_entry e;
        e = '{hz: '0, len_ms: '0};
        case ({t, s})
            {4'd0, 4'd0}: e = '{hz: 16'd2400, len_ms: 16'd40};
            {4'd1, 4'd0}: e = '{hz: 16'd1600, len_ms: 16'd30};
            {4'd1, 4'd1}: e = '{hz: 16'd2200, len_ms: 16'd50};
            {4'd2, 4'd0}: e = '{hz: 16'd1200, len_ms: 16'd80};
            {4'd2, 4'd1}: e = '{hz: 16'd2400, len_ms: 16'd80};
            {4'd3, 4'd0}: e = '{hz: 16'd2400, len_ms: 16'd70};
            {4'd3, 4'd1}: e = '{hz: 16'd500,  len_ms: 16'd110};
            default:      e = '{hz: '0, len_ms: '0};
        endcase
        return e;
    endfunction

endpackage

FILE: design/tsp_if.sv
// tsp_if: valid/ready channels for request beats and result beats
// depends on tsp_pkg for field widths
interface tsp_in_if import tsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TONE_W-1:0] tone;
    logic              mute_value;

    modport source (output valid, output op, output tone, output mute_value, input ready);
    modport sink   (input valid, input op, input tone, input mute_value, output ready);
endinterface

interface tsp_out_if import tsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty;
    logic              playing;
    logic              muted;

    modport source (output valid, output freq_hz, output duty, output playing, output muted,
                    input ready);
    modport sink   (input valid, input freq_hz, input duty, input playing, input muted,
                    output ready);
endinterface

FILE: design/tone_sequence_player.sv
// tone_sequence_player: an accepted request beat passes the input register, then the state update
// and result register, to its result beat; throughput one beat per cycle while the result side is ready,
// set by the single state update stage, which handles one item each cycle that it is not stalled
// a request beat is taken while a result beat still waits, held in the input register
// i_rst_n is synchronous, active low: silent, not muted, tone 0, step 0, elapsed 0, no beats
// depends on tsp_pkg and tsp_if
module tone_sequence_player
    import tsp_pkg::*;
#(
    parameter int NUM_TONES      = NUM_TONES_DEF,
    parameter int STEPS_PER_TONE = STEPS_PER_TONE_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    tsp_in_if.sink    i_in,
    tsp_out_if.source o_out
);

    localparam int CT_W   = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
    localparam int STEP_W = $clog2(STEPS_PER_TONE);
    localparam int IDX_W  = 5;

    // table read with bounds from the parameters
    function automatic t_seq_entry lookup(input logic [IDX_W-1:0] t,
                                          input logic [IDX_W-1:0] s);
        t_seq_entry e;
        e = '{hz: '0, len_ms: '0};
        if (t < IDX_W'(NUM_TONES) && s < IDX_W'(STEPS_PER_TONE)) begin
            e = seq_table(t[TIDX_W-1:0], s[TIDX_W-1:0]);
        end
        return e;
    endfunction

    // input register
    logic              r_in_valid;
    logic [OP_W-1:0]   r_in_op;
    logic [TONE_W-1:0] r_in_tone;
    logic              r_in_mute;

    // player state
    logic              r_playing, n_playing;
    logic              r_muted,   n_muted;
    logic [CT_W-1:0]   r_tone,    n_tone;
    logic [STEP_W-1:0] r_step,    n_step;
    logic [DUR_W-1:0]  r_elapsed, n_elapsed;

    // result register
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_freq;
    logic              r_out_playing;
    logic              r_out_muted;

    logic              in_fire;
    logic              proc_fire;
    t_seq_entry        cur_e;
    t_seq_entry        nxt_e;
    t_seq_entry        play_e;
    t_seq_entry        res_e;
    logic [DUR_W-1:0]  elapsed_inc;
    logic [STEP_W:0]   step_inc;

    assign proc_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    // table reads for the current step, the following step, step 0 of a request and the next state's step
    assign step_inc    = {1'b0, r_step} + (STEP_W+1)'(1);
    assign elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + DUR_W'(1) : r_elapsed;
    assign cur_e       = lookup(IDX_W'(r_tone), IDX_W'(r_step));
    assign nxt_e       = lookup(IDX_W'(r_tone), IDX_W'(step_inc));
    assign play_e      = lookup(IDX_W'(r_in_tone), '0);
    assign res_e       = lookup(IDX_W'(n_tone), IDX_W'(n_step));

    // next state for the item in the input register
    always_comb begin
        n_playing = r_playing;
        n_muted   = r_muted;
        n_tone    = r_tone;
        n_step    = r_step;
        n_elapsed = r_elapsed;
        case (r_in_op)
            OP_TICK: begin
                if (r_playing) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= cur_e.len_ms) begin
                        if (nxt_e.hz == '0 && nxt_e.len_ms == '0) begin
                            n_playing = 1'b0;
                        end else begin
                            n_step    = step_inc[STEP_W-1:0];
                            n_elapsed = '0;
                        end
                    end
                end
            end
            OP_PLAY: begin
                if (!r_muted && IDX_W'(r_in_tone) < IDX_W'(NUM_TONES)) begin
                    if (play_e.hz == '0 && play_e.len_ms == '0) begin
                        n_playing = 1'b0;
                    end else begin
                        n_playing = 1'b1;
                        n_tone    = CT_W'(IDX_W'(r_in_tone));
                        n_step    = '0;
                        n_elapsed = '0;
                    end
                end
            end
            OP_MUTE: begin
                n_muted = r_in_mute;
                if (r_in_mute) begin
                    n_playing = 1'b0;
                end
            end
            default: begin
                n_playing = r_playing;
            end
        endcase
    end

    // input register: takes a beat whenever it is empty or drains this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_fire) begin
            r_in_op   <= i_in.op;
            r_in_tone <= i_in.tone;
            r_in_mute <= i_in.mute_value;
        end
    end

    // player state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_muted   <= 1'b0;
            r_tone    <= '0;
            r_step    <= '0;
            r_elapsed <= '0;
        end else if (proc_fire) begin
            r_playing <= n_playing;
            r_muted   <= n_muted;
            r_tone    <= n_tone;
            r_step    <= n_step;
            r_elapsed <= n_elapsed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire) begin
            r_out_freq    <= n_playing ? res_e.hz : '0;
            r_out_playing <= n_playing;
            r_out_muted   <= n_muted;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.freq_hz = r_out_freq;
    assign o_out.duty    = r_out_playing ? SOUND_DUTY : '0;
    assign o_out.playing = r_out_playing;
    assign o_out.muted   = r_out_muted;

`ifndef SYNTHESIS
    // a sounding sequence is never muted
    a_mute_silences: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_muted |-> !r_playing)
        else $error("playing while muted");

    // the step index stays inside the table row while sounding
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (IDX_W'(r_step) < IDX_W'(STEPS_PER_TONE)))
        else $error("step index out of range");

    // a waiting item stays in the input register until processed
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> r_in_valid)
        else $error("request lost from input register");

    // a processed item always yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |=> r_out_valid)
        else $error("result beat missing");

    // a new step starts with a cleared elapsed count
    a_step_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && n_playing && (n_step != r_step)) |=> (r_elapsed == '0))
        else $error("elapsed count not cleared at step start");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for tone_sequence_player, with a scoreboard class that predicts
// every result beat and random idling on both channels
// depends on tsp_pkg, tsp_if and the tone_sequence_player rtl
module tb_top;
    import tsp_pkg::*;

    localparam int N_TONES      = NUM_TONES_DEF;
    localparam int N_STEPS      = STEPS_PER_TONE_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 10;

    // op code the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic [DUTY_W-1:0] duty;
        logic              playing;
        logic              muted;
    } t_player_out;

    // predicts the player and checks its result beats in order
    class tone_scoreboard;
        bit               snd_on;
        bit               mute_on;
        int unsigned      cur_tone;
        int unsigned      cur_step;
        logic [DUR_W-1:0] elapsed;
        t_player_out      predicted_q[$];
        int               errors;

        function new();
            snd_on   = 1'b0;
            mute_on  = 1'b0;
            cur_tone = 0;
            cur_step = 0;
            elapsed  = '0;
            errors   = 0;
        endfunction

        // fixed tone table, anything outside the listed slots is an end step
        function void step_entry(int unsigned t, int unsigned s,
                                 output logic [FREQ_W-1:0] hz, output logic [DUR_W-1:0] len);
            hz  = '0;
            len = '0;
            if (t < N_TONES && s < N_STEPS) begin
                case ({t[3:0], s[3:0]})
                    {4'd0, 4'd0}: begin hz = 16'd2400; len = 16'd40;  end
                    {4'd1, 4'd0}: begin hz = 16'd1600; len = 16'd30;  end
                    {4'd1, 4'd1}: begin hz = 16'd2200; len = 16'd50;  end
                    {4'd2, 4'd0}: begin hz = 16'd1200; len = 16'd80;  end
                    {4'd2, 4'd1}: begin hz = 16'd2400; len = 16'd80;  end
                    {4'd3, 4'd0}: begin hz = 16'd2400; len = 16'd70;  end
                    {4'd3, 4'd1}: begin hz = 16'd500;  len = 16'd110; end
                    default: ;
                endcase
            end
        endfunction

        // an end step silences and keeps tone and step as they were
        function void enter_step(int unsigned t, int unsigned s);
            logic [FREQ_W-1:0] hz;
            logic [DUR_W-1:0]  len;
            step_entry(t, s, hz, len);
            if (hz == '0 && len == '0) begin
                snd_on = 1'b0;
            end else begin
                cur_tone = t;
                cur_step = s;
                elapsed  = '0;
                snd_on   = 1'b1;
            end
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [TONE_W-1:0] tone, logic mv);
            logic [FREQ_W-1:0] hz;
            logic [DUR_W-1:0]  len;
            t_player_out       o;
            case (op)
                OP_TICK: begin
                    if (snd_on) begin
                        step_entry(cur_tone, cur_step, hz, len);
                        if (elapsed != ELAPSED_MAX) elapsed = elapsed + DUR_W'(1);
                        if (elapsed >= len) enter_step(cur_tone, cur_step + 1);
                    end
                end
                OP_PLAY: begin
                    if (!mute_on && 32'(tone) < N_TONES) enter_step(32'(tone), 0);
                end
                OP_MUTE: begin
                    mute_on = mv;
                    if (mv) snd_on = 1'b0;
                end
                default: ;
            endcase
            o = '0;
            if (snd_on) begin
                step_entry(cur_tone, cur_step, hz, len);
                o.freq_hz = hz;
                o.duty    = SOUND_DUTY;
            end
            o.playing = snd_on;
            o.muted   = mute_on;
            predicted_q.push_back(o);
        endfunction

        function void check_result(t_player_out got);
            t_player_out exp;
            if (predicted_q.size() == 0) begin
                $error("result beat with nothing expected: freq_hz %0d duty %0d", got.freq_hz,
                       got.duty);
                errors++;
                return;
            end
            exp = predicted_q.pop_front();
            if (got.freq_hz !== exp.freq_hz) begin
                $error("freq_hz: expected %0d, actual %0d", exp.freq_hz, got.freq_hz);
                errors++;
            end
            if (got.duty !== exp.duty) begin
                $error("duty: expected %0d, actual %0d", exp.duty, got.duty);
                errors++;
            end
            if (got.playing !== exp.playing) begin
                $error("playing: expected %0b, actual %0b", exp.playing, got.playing);
                errors++;
            end
            if (got.muted !== exp.muted) begin
                $error("muted: expected %0b, actual %0b", exp.muted, got.muted);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsp_in_if  in_if ();
    tsp_out_if out_if ();

    tone_sequence_player dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    tone_scoreboard sb = new();
    int             n_sent = 0;
    int             cycles = 0;
    bit             calm = 1'b0;
    int             stall_left = 0;

    always #1 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: ready drops in short random bursts until the calm tail
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result('{freq_hz: out_if.freq_hz, duty: out_if.duty,
                              playing: out_if.playing, muted: out_if.muted});
    end

    // one request beat, held until accepted
    task automatic send_beat(logic [OP_W-1:0] op, logic [TONE_W-1:0] tone, logic mv);
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.tone       <= tone;
        in_if.mute_value <= mv;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(op, tone, mv);
        n_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // tick with junk in the unused fields
    task automatic send_tick();
        send_beat(OP_TICK, TONE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        send_beat(OP_W'($urandom_range(0, 3)), TONE_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        if (sb.pending() != 0) begin
            in_if.valid <= 1'b0;
            while (sb.pending() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        int n_ticks;
        int n_noise;
        in_if.valid      <= 1'b0;
        in_if.op         <= OP_TICK;
        in_if.tone       <= '0;
        in_if.mute_value <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: spare op, silent tick, bad tones, restarts, mute behavior
        send_beat(OP_SPARE, 3'd7, 1'b1);
        send_beat(OP_TICK, 3'd0, 1'b0);
        send_beat(OP_PLAY, 3'd4, 1'b0);
        send_beat(OP_PLAY, 3'd7, 1'b1);
        send_beat(OP_PLAY, 3'd0, 1'b0);
        send_beat(OP_TICK, 3'd5, 1'b1);
        send_beat(OP_PLAY, 3'd1, 1'b0);
        send_beat(OP_PLAY, 3'd2, 1'b1);
        send_beat(OP_PLAY, 3'd3, 1'b0);
        send_beat(OP_SPARE, 3'd0, 1'b0);
        send_beat(OP_MUTE, 3'd0, 1'b1);
        send_beat(OP_PLAY, 3'd2, 1'b0);
        send_beat(OP_TICK, 3'd0, 1'b0);
        send_beat(OP_MUTE, 3'd7, 1'b0);
        send_beat(OP_TICK, 3'd0, 1'b0);
        send_beat(OP_PLAY, 3'd5, 1'b0);
        send_beat(OP_PLAY, 3'd6, 1'b1);
        send_beat(OP_PLAY, 3'd3, 1'b0);
        send_beat(OP_MUTE, 3'd0, 1'b0);
        send_beat(OP_MUTE, 3'd2, 1'b1);
        send_beat(OP_MUTE, 3'd0, 1'b1);
        send_beat(OP_MUTE, 3'd0, 1'b0);
        send_beat(OP_PLAY, 3'd1, 1'b0);
        send_beat(OP_TICK, 3'd7, 1'b1);
        drain();

        // random: mostly a play followed by a run of ticks, with noise mixed in
        while (n_sent < RANDOM_ITEMS) begin
            if (n_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (n_sent >= RANDOM_ITEMS / 2 && n_sent < RANDOM_ITEMS / 2 + 200) drain();
            if ($urandom_range(0, 9) < 7) begin
                if (sb.mute_on && $urandom_range(0, 3) != 0)
                    send_beat(OP_MUTE, TONE_W'($urandom_range(0, 7)), 1'b0);
                send_beat(OP_PLAY, TONE_W'($urandom_range(0, N_TONES - 1)),
                          1'($urandom_range(0, 1)));
                n_ticks = $urandom_range(0, 200);
                repeat (n_ticks) begin
                    if ($urandom_range(0, 29) == 0) send_noise();
                    else send_tick();
                end
            end else begin
                n_noise = $urandom_range(1, 5);
                repeat (n_noise) send_noise();
            end
        end

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
